>>> rtl/core/cfmc_pkg.sv
// ----------------------------------------------------------------------------
// cfmc_pkg
// Shared types and constants for the circular FIFO with match count.
// ----------------------------------------------------------------------------
`default_nettype none

package cfmc_pkg;

    localparam int READ_W  = 32;
    localparam int COUNT_W = 4;

    localparam logic [READ_W-1:0] RD_EMPTY = {READ_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_ENQ   = 2'd0,
        ACT_DEQ   = 2'd1,
        ACT_COUNT = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_COUNT = 1'b1
    } state_t;

    typedef struct packed {
        logic wr;
        logic shift;
        logic wrap;
    } chain_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/circular_fifo_with_match_count.sv
// ----------------------------------------------------------------------------
// circular_fifo_with_match_count
// FIFO of signed values holding DEPTH-1 items, with a match count action.
// ----------------------------------------------------------------------------
// An action is taken when start is high and busy is low. For enqueue, dequeue
// and the unused code the result is strobed on done in the next cycle and a
// new start is taken in that same cycle. For count, busy is high while the
// chain of cells rotates once past the compare at cell zero, and the count is
// strobed on done in the cycle after the last step. Results are shown for
// exactly one cycle and cannot be held.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_fifo_with_match_count #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         action,
    input  wire logic signed [cfmc_pkg::READ_W-1:0] data_value,
    output logic                                    done,
    output logic signed [cfmc_pkg::READ_W-1:0]      read_value,
    output logic                                    error_flag,
    output logic      [cfmc_pkg::COUNT_W-1:0]       match_count
);

    localparam int OCC_W = $clog2(DEPTH);
    localparam int MC_W  = (OCC_W > cfmc_pkg::COUNT_W) ? OCC_W : cfmc_pkg::COUNT_W;

    cfmc_pkg::state_t state_reg;
    cfmc_pkg::state_t state_next;

    logic [OCC_W-1:0]      occ_reg;
    logic [OCC_W-1:0]      occ_next;
    logic [OCC_W-1:0]      step_reg;
    logic [OCC_W-1:0]      step_next;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [DATA_WIDTH-1:0] key_next;
    logic [MC_W-1:0]       acc_reg;
    logic [MC_W-1:0]       acc_next;

    logic                         done_reg;
    logic                         done_next;
    logic [cfmc_pkg::READ_W-1:0]  read_value_reg;
    logic [cfmc_pkg::READ_W-1:0]  read_value_next;
    logic                         error_flag_reg;
    logic                         error_flag_next;
    logic [cfmc_pkg::COUNT_W-1:0] match_count_reg;
    logic [cfmc_pkg::COUNT_W-1:0] match_count_next;

    cfmc_pkg::chain_ctrl_t       chain_ctrl;
    cfmc_pkg::action_t           act;
    logic [DATA_WIDTH-1:0]       din;
    logic [DATA_WIDTH-1:0]       head;
    logic [cfmc_pkg::READ_W-1:0] head_rd;
    logic                        accept;
    logic                        full;
    logic                        empty;
    logic                        hit;
    logic                        last_step;
    logic [MC_W-1:0]             acc_sum;

    generate
        if (DATA_WIDTH <= cfmc_pkg::READ_W)
        begin : g_din_narrow
            assign din = data_value[DATA_WIDTH-1:0];
        end
        else
        begin : g_din_wide
            assign din = {{(DATA_WIDTH-cfmc_pkg::READ_W){1'b0}}, data_value};
        end

        if (DATA_WIDTH >= cfmc_pkg::READ_W)
        begin : g_rd_wide
            assign head_rd = head[cfmc_pkg::READ_W-1:0];
        end
        else
        begin : g_rd_narrow
            assign head_rd = {{(cfmc_pkg::READ_W-DATA_WIDTH){1'b0}}, head};
        end
    endgenerate

    assign act       = cfmc_pkg::action_t'(action);
    assign accept    = start && (state_reg == cfmc_pkg::ST_IDLE);
    assign full      = (occ_reg == OCC_W'(DEPTH - 1));
    assign empty     = (occ_reg == '0);
    assign last_step = (step_reg == OCC_W'(DEPTH - 1));
    // only the first occ_reg cells of the rotation hold queued entries
    assign hit       = (head == key_reg) && (step_reg < occ_reg);
    assign acc_sum   = acc_reg + MC_W'(hit);

    cfmc_chain #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH)
    ) u_chain (
        .clk    (clk),
        .ctrl   (chain_ctrl),
        .wr_idx (occ_reg),
        .din    (din),
        .head   (head)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfmc_pkg::ST_IDLE:
            begin
                if (accept && (act == cfmc_pkg::ACT_COUNT))
                begin
                    state_next = cfmc_pkg::ST_COUNT;
                end
            end
            cfmc_pkg::ST_COUNT:
            begin
                if (last_step)
                begin
                    state_next = cfmc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cfmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        chain_ctrl       = '0;
        occ_next         = occ_reg;
        step_next        = step_reg;
        key_next         = key_reg;
        acc_next         = acc_reg;
        done_next        = 1'b0;
        read_value_next  = '0;
        error_flag_next  = 1'b0;
        match_count_next = '0;
        unique case (state_reg)
            cfmc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (act)
                        cfmc_pkg::ACT_ENQ:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                error_flag_next = 1'b1;
                            end
                            else
                            begin
                                chain_ctrl.wr = 1'b1;
                                occ_next      = occ_reg + OCC_W'(1);
                            end
                        end
                        cfmc_pkg::ACT_DEQ:
                        begin
                            done_next = 1'b1;
                            if (empty)
                            begin
                                error_flag_next = 1'b1;
                                read_value_next = cfmc_pkg::RD_EMPTY;
                            end
                            else
                            begin
                                read_value_next  = head_rd;
                                chain_ctrl.shift = 1'b1;
                                occ_next         = occ_reg - OCC_W'(1);
                            end
                        end
                        cfmc_pkg::ACT_COUNT:
                        begin
                            key_next  = din;
                            step_next = '0;
                            acc_next  = '0;
                        end
                        cfmc_pkg::ACT_NOP:
                        begin
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            cfmc_pkg::ST_COUNT:
            begin
                chain_ctrl.shift = 1'b1;
                chain_ctrl.wrap  = 1'b1;
                step_next        = step_reg + OCC_W'(1);
                acc_next         = acc_sum;
                if (last_step)
                begin
                    done_next        = 1'b1;
                    match_count_next = acc_sum[cfmc_pkg::COUNT_W-1:0];
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfmc_pkg::ST_IDLE;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg        <= step_next;
        key_reg         <= key_next;
        acc_reg         <= acc_next;
        read_value_reg  <= read_value_next;
        error_flag_reg  <= error_flag_next;
        match_count_reg <= match_count_next;
    end

    assign busy        = (state_reg == cfmc_pkg::ST_COUNT);
    assign done        = done_reg;
    assign read_value  = read_value_reg;
    assign error_flag  = error_flag_reg;
    assign match_count = match_count_reg;

endmodule

`default_nettype wire

>>> rtl/core/cfmc_cell.sv
// ----------------------------------------------------------------------------
// cfmc_cell
// One storage cell of the chain: loads new data or takes its neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module cfmc_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire cfmc_pkg::chain_ctrl_t  ctrl,
    input  wire logic                   sel,
    input  wire logic [DATA_WIDTH-1:0]  din,
    input  wire logic [DATA_WIDTH-1:0]  nbr,
    output logic      [DATA_WIDTH-1:0]  entry
);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.wr && sel)
        begin
            entry_next = din;
        end
        else if (ctrl.shift)
        begin
            entry_next = nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

>>> rtl/core/cfmc_chain.sv
// ----------------------------------------------------------------------------
// cfmc_chain
// Row of storage cells in queue order, oldest entry in cell zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cfmc_chain #(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH      = 16
) (
    input  wire logic                       clk,
    input  wire cfmc_pkg::chain_ctrl_t      ctrl,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_idx,
    input  wire logic [DATA_WIDTH-1:0]      din,
    output logic      [DATA_WIDTH-1:0]      head
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [DATA_WIDTH-1:0] entries [DEPTH];
    logic [DATA_WIDTH-1:0] nbrs    [DEPTH];

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            if (k < DEPTH - 1)
            begin : g_mid
                assign nbrs[k] = entries[k+1];
            end
            else
            begin : g_last
                // wrap closes the ring during a count pass
                assign nbrs[k] = ctrl.wrap ? entries[0] : entries[k];
            end

            cfmc_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .sel   (wr_idx == IDX_W'(k)),
                .din   (din),
                .nbr   (nbrs[k]),
                .entry (entries[k])
            );
        end
    endgenerate

    assign head = entries[0];

endmodule

`default_nettype wire

>>> tb/circular_fifo_with_match_count_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_fifo_with_match_count_tb
// Self-checking bench for the circular FIFO with match count.
// ----------------------------------------------------------------------------
// Commands go in on a start/busy handshake and every command returns one
// result on done. A model of the ring buffer, with its own head and tail and
// storage, predicts each result when the command is taken. The checker pops
// the oldest prediction at every done strobe and compares every field.
// Directed tests cover the empty and full queue, full-scale counts and the
// unused action code. Random traffic then runs in phases picked at random as
// fill-heavy, drain-heavy or balanced, with random command gaps in most phases.
// ----------------------------------------------------------------------------

module circular_fifo_with_match_count_tb;

    import cfmc_pkg::*;

    localparam int FIFO_DEPTH   = 16;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1125;

    typedef struct {
        logic signed [READ_W-1:0]  rd;
        logic                      err;
        logic        [COUNT_W-1:0] cnt;
    } fifo_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                action;
    logic signed [READ_W-1:0]  data_value;
    logic                      done;
    logic signed [READ_W-1:0]  read_value;
    logic                      error_flag;
    logic        [COUNT_W-1:0] match_count;

    logic [READ_W-1:0] fifo_slots [FIFO_DEPTH];
    logic [3:0]        head_idx;
    logic [3:0]        tail_idx;

    fifo_result_t pending_results[$];
    fifo_result_t oldest_result;
    logic [READ_W-1:0] value_pool [6];

    int  error_count;
    int  idle_cycles;
    bit  gaps_off;

    circular_fifo_with_match_count i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .data_value  (data_value),
        .done        (done),
        .read_value  (read_value),
        .error_flag  (error_flag),
        .match_count (match_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic fifo_result_t predict_fifo_action(action_t act, logic [READ_W-1:0] v);
        fifo_result_t r;
        logic [3:0]   idx;
        r.rd  = '0;
        r.err = 1'b0;
        r.cnt = '0;
        case (act)
            ACT_ENQ:
            begin
                if (4'(tail_idx + 4'd1) == head_idx)
                    r.err = 1'b1;
                else
                begin
                    fifo_slots[tail_idx] = v;
                    tail_idx = tail_idx + 4'd1;
                end
            end
            ACT_DEQ:
            begin
                if (head_idx == tail_idx)
                begin
                    r.err = 1'b1;
                    r.rd  = RD_EMPTY;
                end
                else
                begin
                    r.rd = fifo_slots[head_idx];
                    head_idx = head_idx + 4'd1;
                end
            end
            ACT_COUNT:
            begin
                idx = head_idx;
                while (idx != tail_idx)
                begin
                    if (fifo_slots[idx] == v)
                        r.cnt = r.cnt + 1'b1;
                    idx = idx + 4'd1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t: mismatch: %s", $time, what);
        error_count++;
    endtask

    // one command transfer; start stays high when the next command follows at once
    task automatic send_command(action_t act, logic [READ_W-1:0] v);
        int gap;
        gap = gaps_off ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        action     <= act;
        data_value <= v;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_fifo_action(act, v));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending");
            else
            begin
                oldest_result = pending_results.pop_front();
                if (read_value !== oldest_result.rd)
                    report_mismatch($sformatf("read_value %h, expected %h",
                                              read_value, oldest_result.rd));
                if (error_flag !== oldest_result.err)
                    report_mismatch($sformatf("error_flag %b, expected %b",
                                              error_flag, oldest_result.err));
                if (match_count !== oldest_result.cnt)
                    report_mismatch($sformatf("match_count %0d, expected %0d",
                                              match_count, oldest_result.cnt));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("circular_fifo_with_match_count_tb: FAIL");
            $finish;
        end
    end

    task automatic test_empty_queue();
        send_command(ACT_DEQ, $urandom());
        send_command(ACT_COUNT, '0);
        send_command(ACT_NOP, $urandom());
    endtask

    task automatic test_full_queue();
        repeat (FIFO_DEPTH - 1) send_command(ACT_ENQ, 32'hFFFF_FFFF);
        send_command(ACT_ENQ, 32'h8000_0000);
        send_command(ACT_COUNT, 32'hFFFF_FFFF);
        send_command(ACT_COUNT, 32'h8000_0000);
        // held all-ones value must come back without the error flag
        send_command(ACT_DEQ, '0);
        send_command(ACT_ENQ, 32'h7FFF_FFFF);
        send_command(ACT_ENQ, 32'h8000_0000);
        send_command(ACT_COUNT, 32'h7FFF_FFFF);
    endtask

    function automatic logic [READ_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return value_pool[$urandom_range(0, 5)];
        return $urandom();
    endfunction

    function automatic action_t pick_action(int enq_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return ACT_NOP;
        if (r < 22)
            return ACT_COUNT;
        if ($urandom_range(0, 99) < enq_pct)
            return ACT_ENQ;
        return ACT_DEQ;
    endfunction

    task automatic test_random_traffic(int n_items);
        int sent;
        int phase_len;
        int enq_pct;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = '0;
        value_pool[3] = 32'hFFFF_FFFF;
        value_pool[4] = $urandom();
        value_pool[5] = $urandom();
        sent = 0;
        while (sent < n_items)
        begin
            phase_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                default: enq_pct = 50;
            endcase
            gaps_off = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < phase_len && sent < n_items; i++)
            begin
                send_command(pick_action(enq_pct), pick_value());
                sent++;
            end
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        action      = ACT_NOP;
        data_value  = '0;
        error_count = 0;
        idle_cycles = 0;
        gaps_off    = 1'b0;
        head_idx    = '0;
        tail_idx    = '0;
        for (int i = 0; i < FIFO_DEPTH; i++)
            fifo_slots[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_full_queue();
        test_random_traffic(RANDOM_ITEMS);

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (FIFO_DEPTH + 4) @(posedge clk);

        if (error_count == 0)
            $display("circular_fifo_with_match_count_tb: PASS");
        else
            $display("circular_fifo_with_match_count_tb: FAIL");
        $finish;
    end

endmodule
